// ----- rtl/cdm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdm_pkg: shared definitions for the Chebyshev distance matrix block
// Sizes of the row store, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLS     = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int CFG_W   = 7;
  localparam int DIST_W  = 16;
  localparam int DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int IDX_W   = 6;

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_COLS);
  localparam logic [IDX_W-1:0] OVF_ROW    = '1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DIAG
  } state_e;

endpackage

// ----- rtl/chebyshev_distance_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_distance_matrix: streaming pairwise Chebyshev distance rows
// Stores a matrix row by row and emits each lower-triangle distance row.
// ----------------------------------------------------------------------------
// Usage.
// Elements arrive row-major on sample_value_i. A beat is taken at a rising
// edge where start is high and busy is low. A row completes when the number
// of elements set by the configuration register has arrived, or earlier on
// a beat with end_of_matrix_i set; that flag also restarts the row count.
// Beats that do not complete a row leave busy low and give nothing.
// When row i completes, the block compares it with every stored earlier row
// j and emits one result beat per j (maximum absolute element difference),
// then a zero diagonal beat with last_o set. Each result beat is shown for a
// single cycle under result_strobe_o; the receiver cannot stall the block.
// A completing beat of row i keeps busy high while one shared compare unit
// walks every stored element pair once, one pair per cycle, through the two
// read ports of the row store; row 0 has no earlier row and needs no walk.
// The diagonal beat is shown in the first cycle after busy falls.
// A row beyond the store's capacity gives one flagged overflow beat in the
// cycle after it completes. The configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_wdata_i) is always ready and should be written only while
// the block is idle. Reset clears the counters, sets the row length to 64
// and leaves the row store contents undefined; no clearing pass is needed.
// ----------------------------------------------------------------------------
module chebyshev_distance_matrix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  cdm_pkg::sample_t             sample_value_i,
  input  logic                         end_of_matrix_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cdm_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                         result_strobe_o,
  output logic [cdm_pkg::IDX_W-1:0]    row_index_o,
  output logic [cdm_pkg::IDX_W-1:0]    column_index_o,
  output logic [cdm_pkg::DIST_W-1:0]   distance_o,
  output logic                         last_o,
  output logic                         overflow_o
);
  import cdm_pkg::*;

  // Sequencer and counters.
  state_e            state_q, state_d;
  logic [ROW_W:0]    row_count_q, row_count_d;
  logic [COL_W-1:0]  column_count_q, column_count_d;
  logic [CFG_W-1:0]  cols_cfg_q;

  // Row under comparison and the walk position.
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  last_col_q, last_col_d;
  logic [ROW_W-1:0]  j_q, j_d;
  logic [COL_W-1:0]  c_q, c_d;

  // Compare pipeline stage behind the registered store reads.
  logic              p_valid_q;
  logic              p_first_q;
  logic              p_last_q;
  logic [ROW_W-1:0]  p_j_q;
  sample_t           rd_a_q, rd_b_q;
  logic [DIST_W-1:0] best_q;

  // Result register.
  logic              res_strobe_q, res_strobe_d;
  logic [IDX_W-1:0]  res_row_q, res_row_d;
  logic [IDX_W-1:0]  res_col_q, res_col_d;
  logic [DIST_W-1:0] res_dist_q, res_dist_d;
  logic              res_last_q, res_last_d;
  logic              res_ovf_q, res_ovf_d;

  sample_t           mem_q [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

  logic              accept, stored, row_done, issue;
  logic [CFG_W-1:0]  cols_eff;
  logic [CFG_W-1:0]  col_plus_one;
  logic [DIFF_W-1:0] diff_raw, diff_abs;
  logic [DIST_W-1:0] diff_sat, best_now;

  assign cfg_ready_o = 1'b1;

  // A register value of zero acts as one, anything above the row width as
  // the full width.
  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = CFG_W'(1);
    end else if (cols_cfg_q > CFG_W'(MAX_COLS)) begin
      cols_eff = CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg_q;
    end
  end

  assign accept       = start && !busy;
  assign stored       = row_count_q < (ROW_W + 1)'(MAX_ROWS);
  assign col_plus_one = CFG_W'(column_count_q) + CFG_W'(1);
  assign row_done     = (col_plus_one >= cols_eff) || end_of_matrix_i;
  assign mem_we       = accept && stored;

  assign wr_addr   = {row_count_q[ROW_W-1:0], column_count_q};
  assign rd_addr_a = {cur_row_q, c_q};
  assign rd_addr_b = {j_q, c_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && row_done && stored) begin
          state_d = (row_count_q[ROW_W-1:0] == '0) ? ST_DIAG : ST_RUN;
        end
      end
      ST_RUN: begin
        if (c_q == last_col_q && j_q == cur_row_q - ROW_W'(1)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: state_d = ST_DIAG;
      ST_DIAG: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state_q)
      ST_IDLE: busy  = 1'b0;
      ST_RUN:  issue = 1'b1;
      default: begin
        busy  = 1'b1;
        issue = 1'b0;
      end
    endcase
  end

  // Counters and walk position.
  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    cur_row_d      = cur_row_q;
    last_col_d     = last_col_q;
    j_d            = j_q;
    c_d            = c_q;
    if (accept) begin
      if (row_done) begin
        column_count_d = '0;
        if (stored) begin
          cur_row_d   = row_count_q[ROW_W-1:0];
          last_col_d  = column_count_q;
          j_d         = '0;
          c_d         = '0;
          row_count_d = row_count_q + (ROW_W + 1)'(1);
        end
        if (end_of_matrix_i) begin
          row_count_d = '0;
        end
      end else begin
        column_count_d = column_count_q + COL_W'(1);
      end
    end else if (issue) begin
      if (c_q == last_col_q) begin
        c_d = '0;
        j_d = j_q + ROW_W'(1);
      end else begin
        c_d = c_q + COL_W'(1);
      end
    end
  end

  // Shared compare unit: absolute difference and running maximum.
  assign diff_raw = DIFF_W'(rd_a_q) - DIFF_W'(rd_b_q);
  assign diff_abs = diff_raw[DIFF_W-1] ? (DIFF_W'(0) - diff_raw) : diff_raw;

  always_comb begin
    if (diff_abs > DIFF_W'({DIST_W{1'b1}})) begin
      diff_sat = '1;
    end else begin
      diff_sat = diff_abs[DIST_W-1:0];
    end
    if (p_first_q || diff_sat > best_q) begin
      best_now = diff_sat;
    end else begin
      best_now = best_q;
    end
  end

  // Result selection; the three sources never coincide.
  always_comb begin
    res_strobe_d = 1'b0;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    res_dist_d   = res_dist_q;
    res_last_d   = res_last_q;
    res_ovf_d    = res_ovf_q;
    if (accept && row_done && !stored) begin
      res_strobe_d = 1'b1;
      res_row_d    = OVF_ROW;
      res_col_d    = '0;
      res_dist_d   = '0;
      res_last_d   = 1'b1;
      res_ovf_d    = 1'b1;
    end else if (p_valid_q && p_last_q) begin
      res_strobe_d = 1'b1;
      res_row_d    = IDX_W'(cur_row_q);
      res_col_d    = IDX_W'(p_j_q);
      res_dist_d   = best_now;
      res_last_d   = 1'b0;
      res_ovf_d    = 1'b0;
    end else if (state_q == ST_DIAG) begin
      res_strobe_d = 1'b1;
      res_row_d    = IDX_W'(cur_row_q);
      res_col_d    = IDX_W'(cur_row_q);
      res_dist_d   = '0;
      res_last_d   = 1'b1;
      res_ovf_d    = 1'b0;
    end
  end

  // Row store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= sample_value_i;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_count_q    <= '0;
      column_count_q <= '0;
      cols_cfg_q     <= COLS_RESET;
      p_valid_q      <= 1'b0;
      res_strobe_q   <= 1'b0;
    end else begin
      state_q        <= state_d;
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
      p_valid_q      <= issue;
      res_strobe_q   <= res_strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cols_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_row_q  <= cur_row_d;
    last_col_q <= last_col_d;
    j_q        <= j_d;
    c_q        <= c_d;
    p_first_q  <= (c_q == '0);
    p_last_q   <= (c_q == last_col_q);
    p_j_q      <= j_q;
    if (p_valid_q) begin
      best_q <= best_now;
    end
    res_row_q  <= res_row_d;
    res_col_q  <= res_col_d;
    res_dist_q <= res_dist_d;
    res_last_q <= res_last_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign result_strobe_o = res_strobe_q;
  assign row_index_o     = res_row_q;
  assign column_index_o  = res_col_q;
  assign distance_o      = res_dist_q;
  assign last_o          = res_last_q;
  assign overflow_o      = res_ovf_q;

endmodule
